// ===== design/quadrature_encoder_debounced_decoder_core_defines.svh =====
// Assertion macros shared by the decoder core.
`ifndef QUADRATURE_ENCODER_DEBOUNCED_DECODER_CORE_DEFINES_SVH
`define QUADRATURE_ENCODER_DEBOUNCED_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QEDD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define QEDD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/qedd_pkg.sv =====
`timescale 1ns / 1ps
package qedd_pkg;

  typedef logic [1:0] phases_t;
  typedef logic [1:0] gray_pos_t;
  typedef logic [7:0] lockout_t;
  typedef logic signed [3:0] substep_t;
  typedef logic signed [1:0] step_t;

  typedef struct packed {
    phases_t prev;
    phases_t cur;
  } phase_pair_t;

  localparam lockout_t LOCKOUT_TIME_RESET = 8'd10;

  localparam step_t STEP_NONE = 2'sd0;
  localparam step_t STEP_CW   = 2'sd1;
  localparam step_t STEP_CCW  = -2'sd1;

  localparam gray_pos_t POS_DIFF_UP   = 2'd1;
  localparam gray_pos_t POS_DIFF_DOWN = 2'd3;

  localparam substep_t SUBSTEP_WRAP_UP   = 4'sd4;
  localparam substep_t SUBSTEP_WRAP_DOWN = -4'sd4;
  localparam substep_t SUBSTEP_ZERO      = 4'sd0;
  localparam substep_t SUBSTEP_MIN       = -4'sd3;
  localparam substep_t SUBSTEP_MAX       = 4'sd3;

  // Gray position of a (B, A) pair: 00=0, 01=1, 11=2, 10=3.
  function automatic gray_pos_t gray_pos(input phases_t p);
    gray_pos = {p[1], p[1] ^ p[0]};
  endfunction

endpackage

// ===== design/quadrature_encoder_debounced_decoder_core.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Word contents
// s_axis    in         tdata[0] phase_a, tdata[1] phase_b
// m_axis    out        tdata[1:0] step (signed)
// cfg       in         cfg_wr_data = lockout_time, written when cfg_wr_en is high
//
// One word is taken per cycle while a low m_axis_tready does not hold the result register;
// a result word is valid once its input word has passed the input and result registers.
// The input register feeds the latch and sub-step logic, which loads the result register.
// While the result register is held by a low m_axis_tready, a single input word waits
// in the input register and s_axis_tready drops once that register is full.
// Synchronous reset clears both valid flags, the lockouts, the latched pair and the count,
// and sets lockout_time to 10.
`include "quadrature_encoder_debounced_decoder_core_defines.svh"
module quadrature_encoder_debounced_decoder_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] phase_a, [1] phase_b, [7:2] zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [1:0] step, [7:2] zero
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data
);

  qedd_pkg::lockout_t    lockout_time;
  logic                  in_valid;
  qedd_pkg::phases_t     in_phases;
  logic                  out_valid;
  qedd_pkg::step_t       out_step;
  logic                  advance;
  qedd_pkg::phase_pair_t pair;
  qedd_pkg::step_t       step_next;
  qedd_pkg::substep_t    count;

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {6'b0, out_step};

  always_ff @(posedge clk) begin
    if (rst) begin
      lockout_time <= qedd_pkg::LOCKOUT_TIME_RESET;
    end else if (cfg_wr_en) begin
      lockout_time <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_phases <= s_axis_tdata[1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_step <= step_next;
    end
  end

  qedd_latch u_latch (
    .clk          (clk),
    .rst          (rst),
    .en           (advance),
    .lockout_time (lockout_time),
    .sample       (in_phases),
    .pair         (pair)
  );

  qedd_count u_count (
    .clk       (clk),
    .rst       (rst),
    .en        (advance),
    .pair      (pair),
    .step_next (step_next),
    .count     (count)
  );

  `QEDD_ASSERT_NOW(a_count_range, 1'b1, (count >= qedd_pkg::SUBSTEP_MIN) && (count <= qedd_pkg::SUBSTEP_MAX), "sub-step count out of range")
  `QEDD_ASSERT_NEXT(a_step_clears_count, advance, (out_step == qedd_pkg::STEP_NONE) || (count == qedd_pkg::SUBSTEP_ZERO), "detent emitted without clearing the count")
  `QEDD_ASSERT_NEXT(a_state_holds, !advance, $stable(pair.prev) && $stable(count), "decoder state moved without a word")

endmodule

// ===== design/qedd_latch.sv =====
`timescale 1ns / 1ps
module qedd_latch (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  qedd_pkg::lockout_t    lockout_time,
  input  qedd_pkg::phases_t     sample,
  output qedd_pkg::phase_pair_t pair
);

  qedd_pkg::lockout_t lockout [2];
  qedd_pkg::lockout_t lockout_next [2];
  qedd_pkg::phases_t  latched;
  qedd_pkg::phases_t  latched_next;

  always_comb begin
    qedd_pkg::lockout_t load;
    latched_next = latched;
    for (int ch = 0; ch < 2; ch++) begin
      load = lockout[ch];
      if ((lockout[ch] == '0) && (sample[ch] != latched[ch])) begin
        latched_next[ch] = sample[ch];
        load = lockout_time;
      end
      lockout_next[ch] = (load != '0) ? load - 8'd1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      latched    <= '0;
      lockout[0] <= '0;
      lockout[1] <= '0;
    end else if (en) begin
      latched    <= latched_next;
      lockout[0] <= lockout_next[0];
      lockout[1] <= lockout_next[1];
    end
  end

  assign pair.prev = latched;
  assign pair.cur  = latched_next;

endmodule

// ===== design/qedd_count.sv =====
`timescale 1ns / 1ps
module qedd_count (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  qedd_pkg::phase_pair_t pair,
  output qedd_pkg::step_t       step_next,
  output qedd_pkg::substep_t    count
);

  qedd_pkg::substep_t  count_next;
  qedd_pkg::substep_t  inc;
  qedd_pkg::substep_t  dec;
  qedd_pkg::gray_pos_t diff;

  always_comb begin
    diff       = qedd_pkg::gray_pos(pair.cur) - qedd_pkg::gray_pos(pair.prev);
    inc        = count + 4'sd1;
    dec        = count - 4'sd1;
    count_next = count;
    step_next  = qedd_pkg::STEP_NONE;
    case (diff)
      qedd_pkg::POS_DIFF_UP: begin
        if ((inc == qedd_pkg::SUBSTEP_WRAP_UP) || (inc == qedd_pkg::SUBSTEP_ZERO)) begin
          count_next = qedd_pkg::SUBSTEP_ZERO;
          step_next  = qedd_pkg::STEP_CW;
        end else begin
          count_next = inc;
        end
      end
      qedd_pkg::POS_DIFF_DOWN: begin
        if ((dec == qedd_pkg::SUBSTEP_WRAP_DOWN) || (dec == qedd_pkg::SUBSTEP_ZERO)) begin
          count_next = qedd_pkg::SUBSTEP_ZERO;
          step_next  = qedd_pkg::STEP_CCW;
        end else begin
          count_next = dec;
        end
      end
      default: begin
        count_next = count;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= qedd_pkg::SUBSTEP_ZERO;
    end else if (en) begin
      count <= count_next;
    end
  end

endmodule
